/* rtl/mbrtu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Types, function codes, fixed register addresses and CRC helper shared by
// the Modbus RTU register responder.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

    // configuration register indexes
    localparam logic CFG_REPLY_ADDRESS = 1'b0;
    localparam logic CFG_REGISTER_BASE = 1'b1;

    // function codes
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    // single write flag addresses
    localparam logic [15:0] ADDR_VALVE1   = 16'h0126;
    localparam logic [15:0] ADDR_VALVE2   = 16'h0127;
    localparam logic [15:0] ADDR_VALVE3   = 16'h0128;
    localparam logic [15:0] ADDR_VALVE4   = 16'h0129;
    localparam logic [15:0] ADDR_LINK     = 16'h012A;
    localparam logic [15:0] ADDR_AUTOTUNE = 16'h0149;

    // multiple write save addresses
    localparam logic [15:0] ADDR_SAVE_KP   = 16'h0102;
    localparam logic [15:0] ADDR_SAVE_KI   = 16'h0104;
    localparam logic [15:0] ADDR_SAVE_KD   = 16'h012B;
    localparam logic [15:0] ADDR_SAVE_TMAX = 16'h014A;
    localparam logic [15:0] ADDR_SAVE_TMIN = 16'h014C;

    localparam logic [2:0] SAVE_NONE = 3'd0;
    localparam logic [2:0] SAVE_KP   = 3'd1;
    localparam logic [2:0] SAVE_KI   = 3'd2;
    localparam logic [2:0] SAVE_KD   = 3'd3;
    localparam logic [2:0] SAVE_TMAX = 3'd4;
    localparam logic [2:0] SAVE_TMIN = 3'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] REPLY_ADDRESS_RESET = 8'h01;
    localparam logic [15:0] REGISTER_BASE_RESET = 16'h0100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_TX_RD,
        ST_TX_PUT
    } state_t;

    typedef enum logic [1:0] {
        KIND_READ,
        KIND_SINGLE,
        KIND_MULTI
    } kind_t;

    typedef struct packed {
        logic rx_en;
        logic decode;
        logic copy_rd;
        logic copy_wr;
        logic tx_rd;
        logic tx_put;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_single;
        logic is_multi;
        logic copy_empty;
        logic copy_last;
        logic out_free;
        logic tx_last;
    } ctrl_status_t;

    // CRC-16/MODBUS, one byte
    function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/modbus_rtu_slave_register_responder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_responder
// Modbus RTU slave answering reads and writes of a byte-wide register image.
// ----------------------------------------------------------------------------
// Received bytes (s_tuser low) are taken one per cycle and buffered with a
// running CRC-16/MODBUS; s_tlast marks the frame end. Local image writes
// (s_tuser high) are also taken one per cycle. After a frame end the input
// stalls: the frame is decoded, then for a multiple write each data byte is
// copied (frame buffer read, image write), then each response byte is sent
// (image read, output register load); the stall lasts longer while m_tready
// is low. Dropped frames hold the input only for the decode state. The
// response leaves through an output register that stays full until taken.
module modbus_rtu_slave_register_responder
    import mbrtu_pkg::*;
#(
    parameter int FRAME_BYTES   = 256,
    parameter int IMAGE_BYTES   = 256,
    parameter int MAX_READ_REGS = 29
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte, image_index, image_byte
    input  wire logic        s_tuser,   // command
    input  wire logic        s_tlast,   // frame_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // tx_byte, valve_states, link_enable,
                                        // baseline_go, start_autotune,
                                        // control_go, save_request, zeros
    output logic             m_tlast,   // tx_last
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    mbrtu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    mbrtu_dp #(
        .FRAME_BYTES   (FRAME_BYTES),
        .IMAGE_BYTES   (IMAGE_BYTES),
        .MAX_READ_REGS (MAX_READ_REGS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    assign s_tready = cmd.rx_en;

endmodule
`default_nettype wire

/* rtl/mbrtu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_ctrl
// Sequencer: receive, decode, image copy for multiple writes, and response
// byte streaming.
// ----------------------------------------------------------------------------
module mbrtu_ctrl
    import mbrtu_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tuser,
    input  wire logic         s_tlast,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !s_tuser && s_tlast) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (status.is_multi && !status.copy_empty) begin
                    state_next = ST_COPY_RD;
                end else if (status.is_read || status.is_single || status.is_multi) begin
                    state_next = ST_TX_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY_RD: state_next = ST_COPY_WR;
            ST_COPY_WR: begin
                state_next = status.copy_last ? ST_TX_RD : ST_COPY_RD;
            end
            ST_TX_RD:   state_next = ST_TX_PUT;
            ST_TX_PUT: begin
                if (status.out_free) state_next = status.tx_last ? ST_IDLE : ST_TX_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:    cmd.rx_en   = 1'b1;
            ST_DECODE:  cmd.decode  = 1'b1;
            ST_COPY_RD: cmd.copy_rd = 1'b1;
            ST_COPY_WR: cmd.copy_wr = 1'b1;
            ST_TX_RD:   cmd.tx_rd   = 1'b1;
            ST_TX_PUT:  cmd.tx_put  = status.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/mbrtu_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_dp
// Datapath: frame buffer, running CRC, header capture, frame checks, register
// image, control flags and the response output register.
// ----------------------------------------------------------------------------
module mbrtu_dp
    import mbrtu_pkg::*;
#(
    parameter int FRAME_BYTES   = 256,
    parameter int IMAGE_BYTES   = 256,
    parameter int MAX_READ_REGS = 29
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire ctrl_cmd_t    cmd,
    output ctrl_status_t      status,
    input  wire logic         s_tvalid,
    input  wire logic [23:0]  s_tdata,
    input  wire logic         s_tuser,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_data,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tlast
);

    localparam int FA = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 2);
    localparam int IA = $clog2(IMAGE_BYTES);
    localparam logic [17:0] IMAGE_LIM = 18'(IMAGE_BYTES);
    localparam logic [15:0] QTY_MAX   = 16'(MAX_READ_REGS);
    localparam logic [8:0]  IMAGE_CNT = 9'(IMAGE_BYTES);

    // input fields
    logic [7:0] rx_byte, image_index, image_byte;
    assign rx_byte     = s_tdata[7:0];
    assign image_index = s_tdata[15:8];
    assign image_byte  = s_tdata[23:16];

    logic rx_take, loc_take;
    assign rx_take  = cmd.rx_en && s_tvalid && !s_tuser;
    assign loc_take = cmd.rx_en && s_tvalid && s_tuser && ({1'b0, image_index} < IMAGE_CNT);

    // configuration
    logic [7:0]  reply_reg;
    logic [15:0] base_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reply_reg <= REPLY_ADDRESS_RESET;
            base_reg  <= REGISTER_BASE_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_REPLY_ADDRESS) reply_reg <= cfg_data[7:0];
            if (cfg_index == CFG_REGISTER_BASE) base_reg  <= cfg_data;
        end
    end

    // receive: count, crc, header bytes
    logic [CW-1:0] count_reg;
    logic [15:0]   crc_reg;
    logic [7:0]    fc_reg, addr_hi_reg, addr_lo_reg, qty_hi_reg, qty_lo_reg, bc_reg;
    logic          room;
    assign room = count_reg < CW'(FRAME_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end else if (cmd.decode) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end else if (rx_take) begin
            count_reg <= room ? count_reg + CW'(1) : CW'(FRAME_BYTES + 1);
            crc_reg   <= crc16_add(crc_reg, rx_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (rx_take) begin
            if (count_reg == CW'(1)) fc_reg      <= rx_byte;
            if (count_reg == CW'(2)) addr_hi_reg <= rx_byte;
            if (count_reg == CW'(3)) addr_lo_reg <= rx_byte;
            if (count_reg == CW'(4)) qty_hi_reg  <= rx_byte;
            if (count_reg == CW'(5)) qty_lo_reg  <= rx_byte;
            if (count_reg == CW'(6)) bc_reg      <= rx_byte;
        end
    end

    // frame buffer
    logic [7:0]    fb_mem [FRAME_BYTES];
    logic [7:0]    fb_rdata_reg;
    logic [7:0]    copy_i_reg;
    logic [FA-1:0] fb_raddr;
    assign fb_raddr = FA'(8'd7 + copy_i_reg);

    always_ff @(posedge aclk) begin
        if (rx_take && room) fb_mem[count_reg[FA-1:0]] <= rx_byte;
        if (cmd.copy_rd) fb_rdata_reg <= fb_mem[fb_raddr];
    end

    // frame checks
    logic [15:0] addr, qty;
    logic [15:0] diff;
    logic [17:0] off, rd_end, wr_end;
    logic        above, frame_ok, len8, len_multi;
    assign addr      = {addr_hi_reg, addr_lo_reg};
    assign qty       = {qty_hi_reg, qty_lo_reg};
    assign above     = addr >= base_reg;
    assign diff      = addr - base_reg;
    assign off       = {1'b0, diff, 1'b0};
    assign rd_end    = off + {1'b0, qty, 1'b0};
    assign wr_end    = off + {10'd0, bc_reg};
    assign frame_ok  = (count_reg >= CW'(4)) && (count_reg <= CW'(FRAME_BYTES)) &&
                       (crc_reg == 16'h0000);
    assign len8      = count_reg == CW'(8);
    assign len_multi = 10'(count_reg) == (10'd9 + {2'b00, bc_reg});

    assign status.is_read   = frame_ok && (fc_reg == FC_READ_HOLDING) && len8 &&
                              (qty != 16'd0) && (qty <= QTY_MAX) && above &&
                              (rd_end <= IMAGE_LIM);
    assign status.is_single = frame_ok && (fc_reg == FC_WRITE_SINGLE) && len8;
    assign status.is_multi  = frame_ok && (fc_reg == FC_WRITE_MULTI) && len_multi &&
                              above && (wr_end <= IMAGE_LIM);
    assign status.copy_empty = bc_reg == 8'd0;
    assign status.copy_last  = (copy_i_reg + 8'd1) == bc_reg;

    // save code for the multiple write address
    logic [2:0] save_code;
    always_comb begin
        case (addr)
            ADDR_SAVE_KP:   save_code = SAVE_KP;
            ADDR_SAVE_KI:   save_code = SAVE_KI;
            ADDR_SAVE_KD:   save_code = SAVE_KD;
            ADDR_SAVE_TMAX: save_code = SAVE_TMAX;
            ADDR_SAVE_TMIN: save_code = SAVE_TMIN;
            default:        save_code = SAVE_NONE;
        endcase
    end

    // flag update for a single write
    logic [7:0] flags_reg, flags_new;
    logic       on;
    assign on = qty_lo_reg == 8'h01;
    always_comb begin
        flags_new = flags_reg;
        case (addr)
            ADDR_VALVE1: flags_new[0] = on;
            ADDR_VALVE2: begin
                flags_new[1] = on;
                flags_new[5] = on;
            end
            ADDR_VALVE3: begin
                flags_new[2] = on;
                flags_new[6] = on;
            end
            ADDR_VALVE4: begin
                flags_new[3] = on;
                flags_new[7] = on;
            end
            ADDR_LINK:   flags_new[4] = on;
            ADDR_AUTOTUNE: begin
                flags_new[6] = on;
                if (on) flags_new[7] = 1'b0;
            end
            default:     flags_new = flags_reg;
        endcase
    end

    // response setup at decode
    kind_t        kind_reg;
    logic [IA-1:0] off_reg;
    logic [6:0]   data_len_reg;
    logic [7:0]   len_byte_reg;
    logic [2:0]   save_reg;
    logic [6:0]   tx_idx_reg;
    logic [15:0]  tx_crc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (cmd.decode && status.is_single) begin
            flags_reg <= flags_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            kind_reg     <= status.is_read ? KIND_READ :
                            (status.is_single ? KIND_SINGLE : KIND_MULTI);
            off_reg      <= off[IA-1:0];
            data_len_reg <= status.is_read ? (7'd3 + {qty[5:0], 1'b0}) : 7'd6;
            len_byte_reg <= {1'b0, qty[5:0], 1'b0};
            save_reg     <= status.is_multi ? save_code : SAVE_NONE;
        end
    end

    // copy counter
    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            copy_i_reg <= '0;
        end else if (cmd.copy_wr) begin
            copy_i_reg <= copy_i_reg + 8'd1;
        end
    end

    // register image with per-entry valid bits (reset reads as zero)
    logic [7:0]           image_mem [IMAGE_BYTES];
    logic [IMAGE_BYTES-1:0] image_vld_reg;
    logic [7:0]           img_rdata_reg;
    logic                 img_rvld_reg;
    logic                 img_we;
    logic [IA-1:0]        img_waddr, img_raddr;
    logic [7:0]           img_wdata;
    logic [6:0]           rd_rel;

    assign img_we    = loc_take || cmd.copy_wr;
    assign img_waddr = cmd.copy_wr ? off_reg + copy_i_reg[IA-1:0] : image_index[IA-1:0];
    assign img_wdata = cmd.copy_wr ? fb_rdata_reg : image_byte;
    assign rd_rel    = tx_idx_reg - 7'd3;
    assign img_raddr = off_reg + IA'(rd_rel);

    always_ff @(posedge aclk) begin
        if (img_we) image_mem[img_waddr] <= img_wdata;
        if (cmd.tx_rd) img_rdata_reg <= image_mem[img_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_vld_reg <= '0;
            img_rvld_reg  <= 1'b0;
        end else begin
            if (img_we) image_vld_reg[img_waddr] <= 1'b1;
            if (cmd.tx_rd) img_rvld_reg <= image_vld_reg[img_raddr];
        end
    end

    // response byte select
    logic [7:0] tx_byte;
    logic       in_data;
    assign in_data       = tx_idx_reg < data_len_reg;
    assign status.tx_last = tx_idx_reg == (data_len_reg + 7'd1);

    always_comb begin
        tx_byte = reply_reg;
        if (in_data) begin
            if (tx_idx_reg == 7'd0) begin
                tx_byte = reply_reg;
            end else if (kind_reg == KIND_READ) begin
                case (tx_idx_reg)
                    7'd1:    tx_byte = FC_READ_HOLDING;
                    7'd2:    tx_byte = len_byte_reg;
                    default: tx_byte = img_rvld_reg ? img_rdata_reg : 8'h00;
                endcase
            end else begin
                case (tx_idx_reg)
                    7'd1:    tx_byte = fc_reg;
                    7'd2:    tx_byte = addr_hi_reg;
                    7'd3:    tx_byte = addr_lo_reg;
                    7'd4:    tx_byte = qty_hi_reg;
                    default: tx_byte = qty_lo_reg;
                endcase
            end
        end else if (tx_idx_reg == data_len_reg) begin
            tx_byte = tx_crc_reg[7:0];
        end else begin
            tx_byte = tx_crc_reg[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            tx_idx_reg <= '0;
            tx_crc_reg <= CRC_INIT;
        end else if (cmd.tx_put) begin
            tx_idx_reg <= tx_idx_reg + 7'd1;
            if (in_data) tx_crc_reg <= crc16_add(tx_crc_reg, tx_byte);
        end
    end

    // output register
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tlast_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.tx_put) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tx_put) begin
            m_tdata_reg <= {5'd0, save_reg, flags_reg, tx_byte};
            m_tlast_reg <= status.tx_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

/* rtl/mbrtu_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_checker
// Port-level checks for the Modbus RTU register responder.
// ----------------------------------------------------------------------------
module mbrtu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // frame end always stalls the input for decode
    a_end_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && s_tlast |=> !s_tready)
        else $error("input taken right after frame end");

    // save code range and zero padding
    a_save_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:16] <= 3'd5) && (m_tdata[23:19] == 5'd0))
        else $error("bad save code or padding");

    // no output right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind modbus_rtu_slave_register_responder mbrtu_checker u_chk (.*);
`default_nettype wire

/* tb/sv/tb_modbus_rtu_slave_register_responder.sv */
// ----------------------------------------------------------------------------
// tb_modbus_rtu_slave_register_responder
// Drives Modbus RTU frames and local image writes into the responder and
// compares every response byte and flag field against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_slave_register_responder
    import mbrtu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_BYTES = 256;
    localparam int FRM_BYTES = 256;
    localparam int MAX_REGS  = 29;

    // one response byte with its side fields
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [3:0] valves;
        logic       link;
        logic       baseline;
        logic       autotune;
        logic       control;
        logic [2:0] save;
    } resp_t;

    // one input item
    typedef struct {
        logic       local_wr;
        logic [7:0] rx_byte;
        logic       frame_end;
        logic [7:0] idx;
        logic [7:0] val;
    } item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;
    wire         m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_REPLY_ADDRESS;
    logic [15:0] cfg_data = '0;

    modbus_rtu_slave_register_responder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic [7:0]  rx_buf [FRM_BYTES];
    int          rx_cnt;
    logic [15:0] rx_crc;
    logic [7:0]  img [IMG_BYTES];
    logic [7:0]  flags;
    logic [7:0]  my_addr;
    logic [15:0] reg_base;

    resp_t expected_bytes[$];
    int    errors = 0;

    function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
        c ^= {8'h00, b};
        for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic void set_bit(int b, logic on);
        flags[b] = on;
    endfunction

    // queue a response frame with its CRC
    function automatic void queue_reply(logic [7:0] tx[$], logic [2:0] save);
        logic [15:0] c;
        resp_t r;
        c = 16'hFFFF;
        foreach (tx[i]) c = crc_byte(c, tx[i]);
        tx.push_back(c[7:0]);
        tx.push_back(c[15:8]);
        foreach (tx[i]) begin
            r.tx_byte = tx[i];
            r.tx_last = (i == tx.size() - 1);
            r.valves = flags[3:0];
            r.link = flags[4];
            r.baseline = flags[5];
            r.autotune = flags[6];
            r.control = flags[7];
            r.save = save;
            expected_bytes.push_back(r);
        end
    endfunction

    function automatic void decode_frame();
        logic [7:0]  tx[$];
        logic [15:0] addr, qty;
        int          off, bc;
        logic        on;
        logic [2:0]  save;
        if (rx_cnt < 4 || rx_cnt > FRM_BYTES || rx_crc != 0) return;
        if ((rx_buf[1] == FC_READ_HOLDING || rx_buf[1] == FC_WRITE_SINGLE) && rx_cnt != 8)
            return;
        addr = {rx_buf[2], rx_buf[3]};
        qty  = {rx_buf[4], rx_buf[5]};
        off  = (addr < reg_base) ? -1 : (int'(addr) - int'(reg_base)) * 2;
        case (rx_buf[1])
            FC_READ_HOLDING: begin
                if (qty == 0 || qty > MAX_REGS) return;
                if (off < 0 || off + qty * 2 > IMG_BYTES) return;
                tx = {my_addr, FC_READ_HOLDING, 8'(qty * 2)};
                for (int i = 0; i < qty * 2; i++) tx.push_back(img[off + i]);
                queue_reply(tx, SAVE_NONE);
            end
            FC_WRITE_SINGLE: begin
                on = (rx_buf[5] == 8'h01);
                case (addr)
                    ADDR_VALVE1: set_bit(0, on);
                    ADDR_VALVE2: begin set_bit(1, on); set_bit(5, on); end
                    ADDR_VALVE3: begin set_bit(2, on); set_bit(6, on); end
                    ADDR_VALVE4: begin set_bit(3, on); set_bit(7, on); end
                    ADDR_LINK:   set_bit(4, on);
                    ADDR_AUTOTUNE: begin
                        set_bit(6, on);
                        if (on) set_bit(7, 1'b0);
                    end
                    default: ;
                endcase
                tx = {my_addr, rx_buf[1], rx_buf[2], rx_buf[3], rx_buf[4], rx_buf[5]};
                queue_reply(tx, SAVE_NONE);
            end
            FC_WRITE_MULTI: begin
                if (rx_cnt < 9) return;
                bc = rx_buf[6];
                if (rx_cnt != 9 + bc) return;
                if (off < 0 || off + bc > IMG_BYTES) return;
                for (int i = 0; i < bc; i++) img[off + i] = rx_buf[7 + i];
                case (addr)
                    ADDR_SAVE_KP:   save = SAVE_KP;
                    ADDR_SAVE_KI:   save = SAVE_KI;
                    ADDR_SAVE_KD:   save = SAVE_KD;
                    ADDR_SAVE_TMAX: save = SAVE_TMAX;
                    ADDR_SAVE_TMIN: save = SAVE_TMIN;
                    default:        save = SAVE_NONE;
                endcase
                tx = {my_addr, FC_WRITE_MULTI, addr[15:8], addr[7:0], qty[15:8], qty[7:0]};
                queue_reply(tx, save);
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_item(item_t it);
        if (it.local_wr) begin
            img[it.idx] = it.val;
            return;
        end
        if (rx_cnt < FRM_BYTES) begin
            rx_buf[rx_cnt] = it.rx_byte;
            rx_cnt++;
        end else begin
            rx_cnt = FRM_BYTES + 1;
        end
        rx_crc = crc_byte(rx_crc, it.rx_byte);
        if (!it.frame_end) return;
        decode_frame();
        rx_cnt = 0;
        rx_crc = 16'hFFFF;
    endfunction

    // sender side; valid drops only when a gap follows
    task automatic send_item(item_t it);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.local_wr;
        s_tlast  <= it.frame_end;
        s_tdata  <= {it.val, it.idx, it.rx_byte};
        do @(posedge aclk); while (!s_tready);
        predict_item(it);
    endtask

    // send a full frame, CRC appended when good_crc is set
    task automatic send_frame(logic [7:0] body[$], bit good_crc);
        logic [15:0] c;
        item_t it;
        c = 16'hFFFF;
        foreach (body[i]) c = crc_byte(c, body[i]);
        if (good_crc) begin
            body.push_back(c[7:0]);
            body.push_back(c[15:8]);
        end
        foreach (body[i]) begin
            it = '{1'b0, body[i], i == body.size() - 1, 8'($urandom), 8'($urandom)};
            send_item(it);
        end
    endtask

    task automatic local_write(logic [7:0] idx, logic [7:0] val);
        item_t it;
        it = '{1'b1, 8'($urandom), 1'($urandom), idx, val};
        send_item(it);
    endtask

    // stop sending and wait for every queued response byte
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_REPLY_ADDRESS) my_addr = val[7:0];
        else reg_base = val;
    endtask

    // receiver with random stalls
    initial begin
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 4) == 0) m_tready <= ($urandom_range(0, 15) == 0) ? 1'b0 : 1'b1;
            else if ($urandom_range(0, 2) == 0) m_tready <= 1'($urandom_range(0, 1));
        end
    end

    // response checker
    always @(posedge aclk) begin
        resp_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tlast, m_tdata[11:8], m_tdata[12], m_tdata[13],
                   m_tdata[14], m_tdata[15], m_tdata[18:16]};
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected response byte %h", $realtime, got);
                errors++;
            end else begin
                exp_r = expected_bytes.pop_front();
                if (got != exp_r) begin
                    $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
                    errors++;
                end
                if (m_tdata[23:19] != 0) begin
                    $display("%0t: pad bits expected 0 actual %h", $realtime, m_tdata[23:19]);
                    errors++;
                end
            end
        end
    end

    // directed frame table: function, address, quantity or value, good CRC
    typedef struct {
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [15:0] qv;
        bit          good;
    } row_t;

    row_t dir_rows[17] = '{
        '{FC_READ_HOLDING, 16'h0100, 16'd1, 1'b1},
        '{FC_READ_HOLDING, 16'h0100, 16'd29, 1'b1},
        '{FC_READ_HOLDING, 16'h0100, 16'd30, 1'b1},
        '{FC_READ_HOLDING, 16'h0100, 16'd0, 1'b1},
        '{FC_READ_HOLDING, 16'h00FF, 16'd1, 1'b1},
        '{FC_READ_HOLDING, 16'h01F0, 16'd16, 1'b1},
        '{FC_READ_HOLDING, 16'h01F0, 16'd17, 1'b1},
        '{FC_WRITE_SINGLE, ADDR_VALVE1, 16'h0001, 1'b1},
        '{FC_WRITE_SINGLE, ADDR_VALVE2, 16'h0001, 1'b1},
        '{FC_WRITE_SINGLE, ADDR_VALVE3, 16'h0001, 1'b1},
        '{FC_WRITE_SINGLE, ADDR_VALVE4, 16'h0101, 1'b1},
        '{FC_WRITE_SINGLE, ADDR_LINK, 16'h0001, 1'b1},
        '{FC_WRITE_SINGLE, ADDR_AUTOTUNE, 16'h0001, 1'b1},
        '{FC_WRITE_SINGLE, ADDR_VALVE2, 16'h0002, 1'b1},
        '{FC_WRITE_SINGLE, 16'hFFFF, 16'hFFFF, 1'b1},
        '{FC_WRITE_SINGLE, ADDR_VALVE1, 16'h0001, 1'b0},
        '{8'h04, 16'h0100, 16'd1, 1'b1}
    };

    logic [7:0] save_addr_lo[5] = '{8'h02, 8'h04, 8'h2B, 8'h4A, 8'h4C};

    task automatic multi_write(logic [15:0] addr, int bc, logic [15:0] qty, int len_adj);
        logic [7:0] body[$];
        body = {my_addr, FC_WRITE_MULTI, addr[15:8], addr[7:0], qty[15:8], qty[7:0], 8'(bc)};
        for (int i = 0; i < bc + len_adj; i++) body.push_back(8'($urandom));
        send_frame(body, 1'b1);
    endtask

    task automatic rand_frame();
        logic [7:0] body[$];
        logic [15:0] addr;
        int kind;
        kind = $urandom_range(0, 9);
        addr = reg_base + 16'($urandom_range(0, 130));
        if ($urandom_range(0, 7) == 0) addr = 16'($urandom);
        case (kind)
            0, 1, 2: begin
                body = {8'($urandom), FC_READ_HOLDING, addr[15:8], addr[7:0], 8'h00,
                        8'($urandom_range(1, ($urandom_range(0, 5) == 0) ? 40 : 6))};
                send_frame(body, $urandom_range(0, 15) != 0);
            end
            3, 4, 5: begin
                addr = (kind == 5) ? 16'($urandom) : 16'h0126 + 16'($urandom_range(0, 4));
                if ($urandom_range(0, 4) == 0) addr = ADDR_AUTOTUNE;
                body = {8'($urandom), FC_WRITE_SINGLE, addr[15:8], addr[7:0],
                        8'($urandom_range(0, 1) ? 8'h00 : 8'($urandom)),
                        8'($urandom_range(0, 2) ? 8'($urandom_range(0, 1)) : 8'($urandom))};
                send_frame(body, $urandom_range(0, 15) != 0);
            end
            6, 7:
                multi_write((kind == 7) ? {8'h01, save_addr_lo[$urandom_range(0, 4)]} : addr,
                            $urandom_range(0, 8), 16'($urandom),
                            ($urandom_range(0, 9) == 0) ? 1 : 0);
            8: begin
                for (int i = 0; i < $urandom_range(1, 10); i++) body.push_back(8'($urandom));
                send_frame(body, 1'($urandom_range(0, 1)));
            end
            default: local_write(8'($urandom), 8'($urandom));
        endcase
    endtask

    // stimulus
    initial begin
        logic [7:0] body[$];
        rx_cnt = 0;
        rx_crc = 16'hFFFF;
        flags = '0;
        my_addr = REPLY_ADDRESS_RESET;
        reg_base = REGISTER_BASE_RESET;
        foreach (img[i]) img[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // a read straight after reset sees a zero image: 01 03 02 00 00 CRC
        body = {8'h11, FC_READ_HOLDING, 8'h01, 8'h00, 8'h00, 8'h01};
        send_frame(body, 1'b1);

        local_write(8'h00, 8'hFF);
        local_write(8'hFF, 8'hA5);
        foreach (dir_rows[i]) begin
            body = {8'h11, dir_rows[i].fc, dir_rows[i].addr[15:8], dir_rows[i].addr[7:0],
                    dir_rows[i].qv[15:8], dir_rows[i].qv[7:0]};
            send_frame(body, dir_rows[i].good);
        end
        multi_write(16'h0102, 4, 16'd2, 0);
        multi_write(16'h01FF, 2, 16'd1, 0);
        multi_write(16'h0100, 0, 16'd0, 0);
        drain();

        // sweep configuration across extremes with random traffic
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_cfg(CFG_REPLY_ADDRESS, 16'h00FF);
                    write_cfg(CFG_REGISTER_BASE, 16'h0000);
                end
                1: begin
                    write_cfg(CFG_REPLY_ADDRESS, 16'h0000);
                    write_cfg(CFG_REGISTER_BASE, 16'hFFFF);
                end
                2: begin
                    write_cfg(CFG_REPLY_ADDRESS, 16'h005A);
                    write_cfg(CFG_REGISTER_BASE, 16'hFF80);
                end
                default: begin
                    write_cfg(CFG_REPLY_ADDRESS, 16'($urandom));
                    write_cfg(CFG_REGISTER_BASE, 16'h0100 + 16'($urandom_range(0, 64)));
                end
            endcase
            rand_frame();
            drain();
            rand_frame();
            drain();
        end
        write_cfg(CFG_REPLY_ADDRESS, 16'h0001);
        write_cfg(CFG_REGISTER_BASE, 16'h0100);

        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_bytes.size() == 0) $display("Verification passed");
        else begin
            if (expected_bytes.size() != 0)
                $display("%0t: %0d response bytes never arrived", $realtime, expected_bytes.size());
            $display("Verification failed");
        end
        $finish;
    end

    // timeout
    initial begin
        #8ms;
        $display("Verification failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/mbrtu_pkg.sv
rtl/mbrtu_ctrl.sv
rtl/mbrtu_dp.sv
rtl/modbus_rtu_slave_register_responder.sv
rtl/mbrtu_checker.sv
tb/sv/tb_modbus_rtu_slave_register_responder.sv
